>>> rtl/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
package sgm_pkg;

   // Field widths
   localparam int SAMPLE_W = 8;                  // input intensity
   localparam int MAG_W    = 8;                  // magnitude result
   localparam int COORD_W  = 11;                 // centre column and row
   localparam int CSR_W    = 12;                 // configuration data
   localparam int CSR_IDX_W = 1;                 // configuration register index
   localparam int GRAD_W   = SAMPLE_W + 2;       // |gx|, |gy| after 1,2,1 weighting
   localparam int SQ_W     = 2 * GRAD_W + 1;     // gx^2 + gy^2
   localparam int RAD_W    = 2 * MAG_W;          // radicand below saturation
   localparam int REM_W    = MAG_W + 2;          // square root partial remainder

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LINES = 1'b1;

   // Reset values and limits
   localparam logic [CSR_W-1:0] LINE_RESET  = 12'd1280;
   localparam logic [CSR_W-1:0] FRAME_RESET = 12'd720;
   localparam logic [CSR_W-1:0] FRAME_MAX   = 12'd2048;
   localparam int               SPAN_MIN    = 3;   // smallest line or frame
   localparam int               BORDER      = 2;   // first index that completes a window

   // Position and frame marker that travel with a result
   typedef struct packed {
      logic               frame_end;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } meta_type;

   // Request into the square root pipeline
   typedef struct packed {
      logic             sat;
      logic [RAD_W-1:0] value;
      meta_type         meta;
   } sq_req_type;

endpackage

>>> rtl/sgm_isqrt.sv
// Pipelined floor square root with saturation, one result bit per stage.
module sgm_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sgm_pkg::sq_req_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [sgm_pkg::MAG_W-1:0] out_mag,
   output sgm_pkg::meta_type     out_meta
);
   import sgm_pkg::*;

   localparam int STAGES = MAG_W;

   typedef struct packed {
      logic             sat;
      logic [RAD_W-1:0] value;
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] root;
      meta_type         meta;
   } stage_type;

   // One digit of the restoring square root: bring down two bits, try 4*root+1
   function automatic stage_type sqrt_step(input stage_type s);
      stage_type        n;
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      n     = s;
      cur   = {s.rem, s.value[RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({s.root, 2'b01});
      n.value = s.value << 2;
      if (cur >= trial) begin
         n.rem  = REM_W'(cur - trial);
         n.root = {s.root[MAG_W-2:0], 1'b1};
      end else begin
         n.rem  = REM_W'(cur);
         n.root = {s.root[MAG_W-2:0], 1'b0};
      end
      return n;
   endfunction

   logic      valid_ff [STAGES];
   stage_type stage_ff [STAGES];
   stage_type stage_in [STAGES];
   logic      rdy      [STAGES];
   stage_type head;

   // Seed the first stage from the request
   always_comb begin
      head.sat   = in_data.sat;
      head.value = in_data.value;
      head.rem   = '0;
      head.root  = '0;
      head.meta  = in_data.meta;
   end

   // Advance a stage when it is empty or its successor moves
   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      stage_in[0] = sqrt_step(head);
      for (int k = 1; k < STAGES; k++) begin
         stage_in[k] = sqrt_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (rdy[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_mag   = stage_ff[STAGES-1].sat ? {MAG_W{1'b1}} : stage_ff[STAGES-1].root;
   assign out_meta  = stage_ff[STAGES-1].meta;

endmodule

>>> rtl/sobel_gradient_magnitude_top.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream, with line stores.
//
// req_* carries one 8-bit intensity per transfer in raster order. rsp_* carries
// one result for every pixel that completes a 3x3 window whose centre lies
// inside the one-pixel border: the saturated floor square root of gx^2 + gy^2
// and the centre coordinates; rsp_tlast marks the result made by the last pixel
// of a frame. csr_* writes line_length (index 0) and frame_lines (index 1); the
// user writes them only while no pixel is in flight, which the block does not
// enforce; values are clamped to 3..MAX_LINE and 3..2048. One pixel per cycle
// while req_tready is high: each pixel does one read-modify-write of the two
// line stores and issues the read for the next column in the same cycle, so the
// registered read never stalls the stream. A result passes the gradient stage,
// loaded at the edge that transfers its pixel, then the squares stage and eight
// square root stages. Reset clears counters, window and pipeline valid bits and
// restores the register defaults; line stores are not cleared, as the first two
// lines of a frame fill them before they are used. When the receiver stalls,
// empty stages still fill; req_tready falls once all ten stages hold a result.
module sobel_gradient_magnitude_top #(
   parameter int MAX_LINE = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   // Pixel input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] sample
   // Result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // [7:0] magnitude, [18:8] centre_col,
                                                       // [29:19] centre_row, [31:30] zero
   output logic                            rsp_tlast,  // frame_end
   // Configuration
   input  logic                            csr_we,
   input  logic [sgm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sgm_pkg::CSR_W-1:0]       csr_wdata
);
   import sgm_pkg::*;

   localparam int CW  = $clog2(MAX_LINE);
   localparam int LW  = CW + 1;
   localparam int EW  = (LW > CSR_W) ? LW : CSR_W;
   localparam int CXW = (CW > COORD_W) ? CW : COORD_W;

   // Configuration registers
   logic [CSR_W-1:0] line_length_ff;
   logic [CSR_W-1:0] frame_lines_ff;

   // Position and window state
   logic [CW-1:0]       col_ff, col_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [SAMPLE_W-1:0] win_ff [6];

   // Line stores and their registered read data
   logic [SAMPLE_W-1:0] upper_mem [MAX_LINE];
   logic [SAMPLE_W-1:0] lower_mem [MAX_LINE];
   logic [SAMPLE_W-1:0] top_q_ff;
   logic [SAMPLE_W-1:0] mid_q_ff;

   // Pipeline stages
   logic               s1_v_ff;
   logic [GRAD_W-1:0]  s1_ax_ff, s1_ay_ff;
   meta_type           s1_meta_ff;
   logic               s2_v_ff;
   sq_req_type         s2_req_ff;
   logic               s1_rdy, s2_rdy;
   logic               sq_in_ready;

   // Front-end combinational signals
   logic [EW-1:0]       ll_e, len_e, col_p1;
   logic [CSR_W-1:0]    lines, row_p1;
   logic                line_done, frame_done, has_result, accept;
   logic [SAMPLE_W-1:0] bot;
   logic [GRAD_W-1:0]   left, right, upper, lower;
   logic [GRAD_W:0]     dx, dy;
   logic [GRAD_W-1:0]   ax, ay;
   logic [CW-1:0]       col_m1;
   logic [CXW-1:0]      col_x;
   meta_type            meta;
   logic [2*GRAD_W-1:0] px, py;
   logic [SQ_W-1:0]     sq_sum;
   sq_req_type          sq_req;

   logic [MAG_W-1:0]    mag;
   meta_type            out_meta;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_RESET;
         frame_lines_ff <= FRAME_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LINE_LENGTH: line_length_ff <= csr_wdata;
            REG_FRAME_LINES: frame_lines_ff <= csr_wdata;
         endcase
      end
   end

   // Clamp geometry to its usable range
   always_comb begin
      ll_e = EW'(line_length_ff);
      if (ll_e < EW'(SPAN_MIN)) begin
         len_e = EW'(SPAN_MIN);
      end else if (ll_e > EW'(MAX_LINE)) begin
         len_e = EW'(MAX_LINE);
      end else begin
         len_e = ll_e;
      end
      if (frame_lines_ff < CSR_W'(SPAN_MIN)) begin
         lines = CSR_W'(SPAN_MIN);
      end else if (frame_lines_ff > FRAME_MAX) begin
         lines = FRAME_MAX;
      end else begin
         lines = frame_lines_ff;
      end
   end

   // Position bookkeeping
   assign accept     = req_tvalid && req_tready;
   assign col_p1     = EW'(col_ff) + EW'(1);
   assign row_p1     = CSR_W'(row_ff) + CSR_W'(1);
   assign line_done  = (col_p1 >= len_e);
   assign frame_done = line_done && (row_p1 >= lines);
   assign has_result = (row_ff >= COORD_W'(BORDER)) && (col_ff >= CW'(BORDER));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (line_done) begin
            col_in = '0;
            row_in = frame_done ? '0 : row_ff + COORD_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_q_ff;
            win_ff[4] <= mid_q_ff;
            win_ff[5] <= bot;
         end
      end
   end

   // Shift the column down the line stores; prefetch the next column
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_mem[col_ff] <= mid_q_ff;
         lower_mem[col_ff] <= bot;
      end
      top_q_ff <= upper_mem[col_in];
      mid_q_ff <= lower_mem[col_in];
   end

   // Weighted column and row sums, absolute gradients
   always_comb begin
      bot   = req_tdata[SAMPLE_W-1:0];
      left  = GRAD_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + GRAD_W'(win_ff[2]);
      right = GRAD_W'(top_q_ff) + {1'b0, mid_q_ff, 1'b0} + GRAD_W'(bot);
      upper = GRAD_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + GRAD_W'(top_q_ff);
      lower = GRAD_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + GRAD_W'(bot);
      dx    = {1'b0, left} - {1'b0, right};
      dy    = {1'b0, upper} - {1'b0, lower};
      ax    = dx[GRAD_W] ? GRAD_W'(~dx + 1'b1) : dx[GRAD_W-1:0];
      ay    = dy[GRAD_W] ? GRAD_W'(~dy + 1'b1) : dy[GRAD_W-1:0];
   end

   always_comb begin
      col_m1         = col_ff - CW'(1);
      col_x          = CXW'(col_m1);
      meta.col       = col_x[COORD_W-1:0];
      meta.row       = row_ff - COORD_W'(1);
      meta.frame_end = frame_done;
   end

   // Stage ready chain
   assign s2_rdy     = !s2_v_ff || sq_in_ready;
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy;

   // Gradient stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= accept && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && accept && has_result) begin
         s1_ax_ff   <= ax;
         s1_ay_ff   <= ay;
         s1_meta_ff <= meta;
      end
   end

   // Square and sum stage
   always_comb begin
      px           = {{GRAD_W{1'b0}}, s1_ax_ff} * {{GRAD_W{1'b0}}, s1_ax_ff};
      py           = {{GRAD_W{1'b0}}, s1_ay_ff} * {{GRAD_W{1'b0}}, s1_ay_ff};
      sq_sum       = {1'b0, px} + {1'b0, py};
      sq_req.sat   = |sq_sum[SQ_W-1:RAD_W];
      sq_req.value = sq_sum[RAD_W-1:0];
      sq_req.meta  = s1_meta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_v_ff) begin
         s2_req_ff <= sq_req;
      end
   end

   // Square root pipeline; its last stage is the output register
   sgm_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_ready  (sq_in_ready),
      .in_data   (s2_req_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mag   (mag),
      .out_meta  (out_meta)
   );

   assign rsp_tdata = {2'b00, out_meta.row, out_meta.col, mag};
   assign rsp_tlast = out_meta.frame_end;

endmodule
